FILE: src/tmn_pkg.sv
// Package for the trimmed mean normalizer: request and result types,
// derived widths and the constant reciprocals used by the pipeline.
// It depends on nothing; every module of the block refers to it.
package tmn_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + 3;
  localparam int MID_BITS    = SAMPLE_BITS + 2;
  localparam int Q10_BITS    = SAMPLE_BITS - 3;
  localparam int NORM_BITS   = 7;
  localparam int NUM_BITS    = SAMPLE_BITS + NORM_BITS;
  localparam int DIV_STEPS   = NORM_BITS;
  localparam int PRE_STAGES  = 5;
  localparam int STAGES      = PRE_STAGES + DIV_STEPS + 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam int SH3     = MID_BITS + 2;
  localparam int R3_BITS = SH3 - 1;
  localparam logic [R3_BITS-1:0] RECIP3 = R3_BITS'((64'd1 << SH3) / 3 + 1);

  localparam int SH10     = SAMPLE_BITS + 4;
  localparam int R10_BITS = SH10 - 3;
  localparam logic [R10_BITS-1:0] RECIP10 = R10_BITS'((64'd1 << SH10) / 10 + 1);

  localparam logic [NORM_BITS-1:0] PCT_FULL = NORM_BITS'(100);
  localparam logic [3:0]           QUANT_STEP = 4'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_MIN = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_MAX = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic [SAMPLE_BITS-1:0] sample_d;
    logic [SAMPLE_BITS-1:0] sample_e;
  } tmn_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] trimmed_mean;
    logic [SAMPLE_BITS-1:0] quantized_level;
    logic [NORM_BITS-1:0]   normalized_level;
    logic                   range_error;
  } tmn_out_t;

endpackage

FILE: src/trimmed_mean_normalizer_top.sv
// Trimmed mean normalizer: a fourteen-stage pipeline from five samples to
// a percent-of-range level. It depends on tmn_pkg for types and constants.
//
// Usage: a request carries five unsigned samples on sample and is taken at a
// clock edge where sample_valid is high and sample_stall is low. Each request
// gives one result on result, offered with result_valid until an edge where
// result_stall is low. The middle three samples are found as the total less
// the smallest and the largest, averaged, rounded down to a multiple of ten
// and scaled against range_min and range_max by a seven-step restoring
// divider, one quotient bit per stage.
// One request is taken every cycle while sample_stall is low. Empty stages
// close up while the result is stalled, so sample_stall rises only once
// all fourteen stages hold work.
// The calibration registers are written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high, and writes belong in idle periods.
// A synchronous rst empties the pipeline and sets range_min to 0 and
// range_max to full scale.
module trimmed_mean_normalizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  tmn_pkg::tmn_in_t                    sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tmn_pkg::tmn_out_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tmn_pkg::SAMPLE_BITS-1:0]     cfg_data
);

  localparam int SB = tmn_pkg::SAMPLE_BITS;
  localparam int DV = tmn_pkg::PRE_STAGES;
  localparam int LAST = tmn_pkg::STAGES - 1;

  typedef struct packed {
    logic [SB-1:0]                      mean;
    logic [SB-1:0]                      quant;
    logic                               low;
    logic                               high;
    logic                               err;
    logic [tmn_pkg::NUM_BITS-1:0]       rem;
    logic [tmn_pkg::NORM_BITS-1:0]      quo;
  } div_t;

  logic [SB-1:0] range_min;
  logic [SB-1:0] range_max;
  logic [SB-1:0] divisor;

  logic [tmn_pkg::STAGES-1:0] vld;
  logic [tmn_pkg::STAGES-1:0] adv;

  logic [tmn_pkg::SUM_BITS-1:0] s0_sum;
  logic [SB-1:0]                s0_min;
  logic [SB-1:0]                s0_max;
  logic [tmn_pkg::MID_BITS-1:0] s1_mid;
  logic [SB-1:0]                s2_mean;
  logic [SB-1:0]                s3_mean;
  logic [tmn_pkg::Q10_BITS-1:0] s3_q10;
  logic [SB-1:0]                s4_mean;
  logic [SB-1:0]                s4_quant;
  div_t                         dv [tmn_pkg::DIV_STEPS+1];

  logic [SB-1:0] min_ab, min_cd, min_abcd, min_all;
  logic [SB-1:0] max_ab, max_cd, max_abcd, max_all;
  logic [tmn_pkg::SUM_BITS-1:0] sum_all;
  logic [tmn_pkg::MID_BITS+tmn_pkg::R3_BITS-1:0] prod3;
  logic [SB+tmn_pkg::R10_BITS-1:0]               prod10;
  logic [SB-1:0] diff;

  assign cfg_ready = 1'b1;
  assign divisor   = range_max - range_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      range_max <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmn_pkg::REG_RANGE_MIN: range_min <= cfg_data;
        tmn_pkg::REG_RANGE_MAX: range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv[LAST] = !vld[LAST] || !result_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign sample_stall = !adv[0];
  assign result_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= sample_valid;
      end
      for (int i = 1; i < tmn_pkg::STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    min_ab   = (sample.sample_a < sample.sample_b) ? sample.sample_a : sample.sample_b;
    max_ab   = (sample.sample_a < sample.sample_b) ? sample.sample_b : sample.sample_a;
    min_cd   = (sample.sample_c < sample.sample_d) ? sample.sample_c : sample.sample_d;
    max_cd   = (sample.sample_c < sample.sample_d) ? sample.sample_d : sample.sample_c;
    min_abcd = (min_ab < min_cd) ? min_ab : min_cd;
    max_abcd = (max_ab > max_cd) ? max_ab : max_cd;
    min_all  = (min_abcd < sample.sample_e) ? min_abcd : sample.sample_e;
    max_all  = (max_abcd > sample.sample_e) ? max_abcd : sample.sample_e;
    sum_all  = tmn_pkg::SUM_BITS'(sample.sample_a) + tmn_pkg::SUM_BITS'(sample.sample_b)
             + tmn_pkg::SUM_BITS'(sample.sample_c) + tmn_pkg::SUM_BITS'(sample.sample_d)
             + tmn_pkg::SUM_BITS'(sample.sample_e);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_sum <= sum_all;
      s0_min <= min_all;
      s0_max <= max_all;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_mid <= tmn_pkg::MID_BITS'(s0_sum - tmn_pkg::SUM_BITS'(s0_min)
                                          - tmn_pkg::SUM_BITS'(s0_max));
    end
  end

  // Division by three and by ten use a scaled reciprocal that is exact
  // over the whole input range.
  assign prod3 = (tmn_pkg::MID_BITS + tmn_pkg::R3_BITS)'(s1_mid)
               * (tmn_pkg::MID_BITS + tmn_pkg::R3_BITS)'(tmn_pkg::RECIP3);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_mean <= prod3[tmn_pkg::SH3 +: SB];
    end
  end

  assign prod10 = (SB + tmn_pkg::R10_BITS)'(s2_mean)
                * (SB + tmn_pkg::R10_BITS)'(tmn_pkg::RECIP10);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_mean <= s2_mean;
      s3_q10  <= prod10[tmn_pkg::SH10 +: tmn_pkg::Q10_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_mean  <= s3_mean;
      s4_quant <= SB'(SB'(s3_q10) * SB'(tmn_pkg::QUANT_STEP));
    end
  end

  assign diff = s4_quant - range_min;

  always_ff @(posedge clk) begin
    if (adv[DV]) begin
      dv[0].mean  <= s4_mean;
      dv[0].quant <= s4_quant;
      dv[0].low   <= s4_quant <= range_min;
      dv[0].high  <= s4_quant >= range_max;
      dv[0].err   <= range_max <= range_min;
      dv[0].rem   <= tmn_pkg::NUM_BITS'(diff) * tmn_pkg::NUM_BITS'(tmn_pkg::PCT_FULL);
      dv[0].quo   <= '0;
    end
  end

  for (genvar g = 0; g < tmn_pkg::DIV_STEPS; g++) begin : g_div
    localparam int SHIFT = tmn_pkg::DIV_STEPS - 1 - g;
    logic [tmn_pkg::NUM_BITS-1:0] trial;
    logic                         fits;
    div_t                         step_next;

    always_comb begin
      trial     = tmn_pkg::NUM_BITS'(divisor) << SHIFT;
      fits      = dv[g].rem >= trial;
      step_next = dv[g];
      step_next.quo[SHIFT] = fits;
      if (fits) begin
        step_next.rem = dv[g].rem - trial;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[DV+1+g]) begin
        dv[g+1] <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      result.trimmed_mean    <= dv[tmn_pkg::DIV_STEPS].mean;
      result.quantized_level <= dv[tmn_pkg::DIV_STEPS].quant;
      result.range_error     <= dv[tmn_pkg::DIV_STEPS].err;
      if (dv[tmn_pkg::DIV_STEPS].err || dv[tmn_pkg::DIV_STEPS].low) begin
        result.normalized_level <= '0;
      end else if (dv[tmn_pkg::DIV_STEPS].high) begin
        result.normalized_level <= tmn_pkg::PCT_FULL;
      end else begin
        result.normalized_level <= dv[tmn_pkg::DIV_STEPS].quo;
      end
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (&vld))
    else $error("Request stalled while a pipeline stage was empty.");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_error |-> result.normalized_level == '0)
    else $error("Range error reported with a nonzero level.");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.normalized_level <= tmn_pkg::PCT_FULL)
    else $error("Normalized level above full scale.");

  a_quant_below_mean: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.quantized_level <= result.trimmed_mean
      && (result.trimmed_mean - result.quantized_level) < SB'(tmn_pkg::QUANT_STEP))
    else $error("Quantized level is not the mean rounded down to a step.");

endmodule
